### rtl/tfd_pkg.sv
`default_nettype none

package tfd_pkg;

    localparam int unsigned HEADER_CHECK_BYTES = 13;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

    localparam logic [2:0] PH_ID     = 3'd0;
    localparam logic [2:0] PH_LEN_HI = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_CRC_HI = 3'd3;
    localparam logic [2:0] PH_CRC_LO = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_start;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] channel_id;
        logic       last;
        logic       header_ok;
        logic       data_ok;
        logic       length_error;
    } result_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        begin
            c = {crc[7:0], crc[15:8]} ^ {8'h00, b};
            c = c ^ {12'h000, c[7:4]};
            c = c ^ {c[3:0], 12'h000} ^ {3'b000, c[7:0], 5'b00000};
            return c;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/tpeg_frame_deframer_crc_check_unit.sv
// Path from input transfer to result on the m_ port: input register, then result register.
// Throughput: one byte per cycle unless m_ready stalls; only a length error yields a header result.
// A waiting result holds the core; the input register takes one more byte, then s_ready drops.
// Reset: synchronous, active-low aresetn; clears both valid flags and the parser state.
`default_nettype none

module tpeg_frame_deframer_crc_check_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_buffer_start,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic [7:0]      m_channel_id,
    output logic            m_last,
    output logic            m_header_ok,
    output logic            m_data_ok,
    output logic            m_length_error
);
    import tfd_pkg::*;

    logic    advance;
    logic    item_valid;
    item_t   item;
    logic    fire;
    logic    res_valid;
    result_t res;
    result_t m_res;

    assign fire = item_valid && advance;

    tfd_in_stage u_in (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_buffer_start (s_buffer_start),
        .advance        (advance),
        .item_valid     (item_valid),
        .item           (item)
    );

    tfd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    tfd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_out_byte     = m_res.out_byte;
    assign m_channel_id   = m_res.channel_id;
    assign m_last         = m_res.last;
    assign m_header_ok    = m_res.header_ok;
    assign m_data_ok      = m_res.data_ok;
    assign m_length_error = m_res.length_error;

endmodule

`default_nettype wire

### rtl/tfd_in_stage.sv
`default_nettype none

module tfd_in_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic [7:0]     s_data_byte,
    input  wire logic           s_buffer_start,
    input  wire logic           advance,
    output logic                item_valid,
    output tfd_pkg::item_t      item
);
    import tfd_pkg::*;

    logic  in_valid_reg;
    logic  in_valid_next;
    item_t item_reg;

    assign s_ready    = !in_valid_reg || advance;
    assign item_valid = in_valid_reg;
    assign item       = item_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= '{data_byte: s_data_byte, buffer_start: s_buffer_start};
        end
    end

endmodule

`default_nettype wire

### rtl/tfd_core.sv
`default_nettype none

module tfd_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           fire,
    input  wire tfd_pkg::item_t item,
    output logic                res_valid,
    output tfd_pkg::result_t    res
);
    import tfd_pkg::*;

    logic [2:0]  phase_reg,      phase_next;
    logic [7:0]  channel_reg,    channel_next;
    logic [15:0] length_reg,     length_next;
    logic [15:0] rx_crc_reg,     rx_crc_next;
    logic [15:0] count_reg,      count_next;
    logic [15:0] hdr_crc_reg,    hdr_crc_next;
    logic [15:0] data_crc_reg,   data_crc_next;
    logic [15:0] tail_reg,       tail_next;
    logic        halted_reg,     halted_next;

    logic [2:0]  phase_eff;
    logic        halt_eff;
    logic [7:0]  b;
    logic [15:0] hdr_crc_upd;
    logic [15:0] data_crc_upd;
    logic [15:0] tail_upd;
    logic [16:0] count_p1;
    logic [16:0] count_p2;
    logic        is_last;

    assign b         = item.data_byte;
    assign phase_eff = item.buffer_start ? PH_ID : phase_reg;
    assign halt_eff  = item.buffer_start ? 1'b0 : halted_reg;
    assign count_p1  = {1'b0, count_reg} + 17'd1;
    assign count_p2  = {1'b0, count_reg} + 17'd2;
    assign is_last   = count_p1 >= {1'b0, length_reg};
    assign tail_upd  = {tail_reg[7:0], b};

    always_comb begin
        hdr_crc_upd = hdr_crc_reg;
        if (count_reg < 16'(HEADER_CHECK_BYTES)) begin
            hdr_crc_upd = crc_feed(hdr_crc_reg, b);
        end
        data_crc_upd = data_crc_reg;
        if (count_p2 < {1'b0, length_reg}) begin
            data_crc_upd = crc_feed(data_crc_reg, b);
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        channel_next  = channel_reg;
        length_next   = length_reg;
        rx_crc_next   = rx_crc_reg;
        count_next    = count_reg;
        hdr_crc_next  = hdr_crc_reg;
        data_crc_next = data_crc_reg;
        tail_next     = tail_reg;
        halted_next   = halted_reg;
        res_valid     = 1'b0;
        res           = '0;
        if (fire) begin
            phase_next  = phase_eff;
            halted_next = halt_eff;
            if (!halt_eff) begin
                case (phase_eff)
                    PH_LEN_HI: begin
                        length_next  = {b, 8'h00};
                        hdr_crc_next = crc_feed(hdr_crc_reg, b);
                        phase_next   = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        length_next  = {length_reg[15:8], b};
                        hdr_crc_next = crc_feed(hdr_crc_reg, b);
                        if (length_reg[15:8] == 8'h00 && b < 8'd2) begin
                            halted_next      = 1'b1;
                            phase_next       = PH_ID;
                            res_valid        = 1'b1;
                            res.channel_id   = channel_reg;
                            res.length_error = 1'b1;
                        end else begin
                            phase_next = PH_CRC_HI;
                        end
                    end
                    PH_CRC_HI: begin
                        rx_crc_next = {b, 8'h00};
                        phase_next  = PH_CRC_LO;
                    end
                    PH_CRC_LO: begin
                        rx_crc_next   = {rx_crc_reg[15:8], b};
                        count_next    = '0;
                        data_crc_next = CRC_INIT;
                        tail_next     = '0;
                        phase_next    = PH_DATA;
                    end
                    PH_DATA: begin
                        hdr_crc_next   = hdr_crc_upd;
                        data_crc_next  = data_crc_upd;
                        tail_next      = tail_upd;
                        count_next     = count_p1[15:0];
                        res_valid      = 1'b1;
                        res.out_byte   = b;
                        res.channel_id = channel_reg;
                        res.last       = is_last;
                        if (is_last) begin
                            res.header_ok = (hdr_crc_upd ^ CRC_XOROUT) == rx_crc_reg;
                            res.data_ok   = (data_crc_upd ^ CRC_XOROUT) == tail_upd;
                            phase_next    = PH_ID;
                        end
                    end
                    default: begin
                        channel_next = b;
                        hdr_crc_next = crc_feed(CRC_INIT, b);
                        phase_next   = PH_LEN_HI;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_ID;
            channel_reg  <= '0;
            length_reg   <= '0;
            rx_crc_reg   <= '0;
            count_reg    <= '0;
            hdr_crc_reg  <= CRC_INIT;
            data_crc_reg <= CRC_INIT;
            tail_reg     <= '0;
            halted_reg   <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            channel_reg  <= channel_next;
            length_reg   <= length_next;
            rx_crc_reg   <= rx_crc_next;
            count_reg    <= count_next;
            hdr_crc_reg  <= hdr_crc_next;
            data_crc_reg <= data_crc_next;
            tail_reg     <= tail_next;
            halted_reg   <= halted_next;
        end
    end

endmodule

`default_nettype wire

### rtl/tfd_out_stage.sv
`default_nettype none

module tfd_out_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             fire,
    input  wire logic             res_valid,
    input  wire tfd_pkg::result_t res,
    output logic                  advance,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output tfd_pkg::result_t      m_res
);
    import tfd_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;

    assign advance = !out_valid_reg || m_ready;
    assign m_valid = out_valid_reg;
    assign m_res   = out_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire && res_valid) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            out_reg <= res;
        end
    end

endmodule

`default_nettype wire

### rtl/tfd_checker.sv
`default_nettype none

module tfd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic [7:0] m_channel_id,
    input wire logic       m_last,
    input wire logic       m_header_ok,
    input wire logic       m_data_ok,
    input wire logic       m_length_error
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_len_err_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_length_error |-> !m_last && m_out_byte == 8'h00)
        else $error("length error result carries payload");

    a_flags_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !m_header_ok && !m_data_ok)
        else $error("check flag set off the last byte");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_channel_id)
            && $stable(m_last))
        else $error("stalled result changed");

    a_input_taken_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind tpeg_frame_deframer_crc_check_unit tfd_checker u_tfd_checker (.*);

`default_nettype wire
